// ===== design/micon_pkg.sv =====
`default_nettype none

package micon_pkg;

  // Configuration register indexes.
  localparam logic [7:0] REG_TONE_SLACK  = 8'd0;
  localparam logic [7:0] REG_ALPHA_FLOOR = 8'd1;

  // Register values after reset.
  localparam logic [7:0] TONE_SLACK_RESET  = 8'd12;
  localparam logic [7:0] ALPHA_FLOOR_RESET = 8'd24;

  // Tone tracker values after reset and at the start of each image.
  localparam logic [7:0] LOWEST_TONE_RESET  = 8'hff;
  localparam logic [7:0] HIGHEST_TONE_RESET = 8'h00;

  // Saturated channel value.
  localparam logic [7:0] TONE_MAX = 8'hff;

  // Number of bits in one quotient, which is one divider step per bit.
  localparam int unsigned QUO_BITS = 8;

  // Default number of entries in the queue between the front and the back.
  localparam int unsigned QUEUE_DEPTH_DEFAULT = 2;

  // One classified pixel as it travels through the queue.
  typedef struct packed {
    logic       take;   // alpha is nonzero and not below the floor
    logic       last;   // final pixel of the image
    logic [7:0] alpha;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } entry_t;

  // Queue status seen by both sides.
  typedef struct packed {
    logic full;
    logic empty;
  } queue_stat_t;

  // Back end sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_MERGE,
    ST_CHECK
  } back_state_t;

endpackage

`default_nettype wire

// ===== design/micon_front.sv =====
`default_nettype none

// Accepts pixel words and classifies each one as counted or skipped by its alpha.
module micon_front (
  input  wire logic               s_tvalid,
  output logic                    s_tready,
  input  wire logic [31:0]        s_tdata,   // blue[7:0], green[15:8], red[23:16], alpha[31:24]
  input  wire logic               s_tlast,   // last pixel of the image
  input  wire logic [7:0]         alpha_floor,
  input  wire micon_pkg::queue_stat_t q_stat,
  output logic                    push,
  output micon_pkg::entry_t       entry
);

  logic [7:0] alpha;

  assign alpha = s_tdata[31:24];

  // A word is taken whenever the queue has room.
  assign s_tready = !q_stat.full;
  assign push     = s_tvalid && !q_stat.full;

  // Zero alpha is always skipped, so the divider never sees it.
  always_comb begin
    entry.take  = (alpha != 8'd0) && (alpha >= alpha_floor);
    entry.last  = s_tlast;
    entry.alpha = alpha;
    entry.red   = s_tdata[23:16];
    entry.green = s_tdata[15:8];
    entry.blue  = s_tdata[7:0];
  end

endmodule

`default_nettype wire

// ===== design/micon_queue.sv =====
`default_nettype none

// Short first-in first-out queue of classified pixels.
module micon_queue #(
  parameter int unsigned DEPTH = micon_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   push,
  input  wire micon_pkg::entry_t      push_entry,
  input  wire logic                   pop,
  output micon_pkg::entry_t           head,
  output micon_pkg::queue_stat_t      q_stat
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  micon_pkg::entry_t slots [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;

  assign head         = slots[rd_ptr];
  assign q_stat.full  = (count == CNT_FULL);
  assign q_stat.empty = (count == '0);

  // Storage is written only at the write pointer.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  // Pointers wrap at the depth; the count tracks occupancy.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

// ===== design/micon_back.sv =====
`default_nettype none

// Unpremultiplies counted pixels, tracks the tone range and delivers the verdict.
module micon_back (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic [7:0]             tone_slack,
  input  wire micon_pkg::entry_t      head,
  input  wire micon_pkg::queue_stat_t q_stat,
  output logic                        pop,
  output logic                        m_tvalid,
  input  wire logic                   m_tready,
  output logic [7:0]                  m_tdata   // is_mask[0], zero[7:1]
);

  localparam int unsigned LANES = 3;
  localparam int unsigned STEP_W = $clog2(micon_pkg::QUO_BITS);

  micon_pkg::back_state_t state, state_next;

  // Current pixel.
  logic       job_do;
  logic       job_last;
  logic [7:0] job_alpha;

  // Divider lanes: red, green, blue.
  logic [7:0]        rem  [LANES];
  logic [7:0]        quo  [LANES];
  logic              sat  [LANES];
  logic [7:0]        tone [LANES];
  logic [STEP_W-1:0] step;

  // Image state.
  logic [7:0] lowest_tone;
  logic [7:0] highest_tone;
  logic       any_counted;
  logic       rejected;

  // Result register.
  logic out_valid;
  logic out_mask;

  logic [7:0] chan_in [LANES];
  logic [7:0] cmin;
  logic [7:0] cmax;
  logic       exceed;
  logic       emit_ok;
  logic       rej_now;
  logic       cnt_now;

  assign chan_in[0] = head.red;
  assign chan_in[1] = head.green;
  assign chan_in[2] = head.blue;

  assign m_tvalid = out_valid;
  assign m_tdata  = {7'd0, out_mask};

  // Final channel values, saturated where the quotient reaches 255 or more.
  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      tone[i] = sat[i] ? micon_pkg::TONE_MAX : quo[i];
    end
    cmin = (tone[0] < tone[1]) ? tone[0] : tone[1];
    if (tone[2] < cmin) begin
      cmin = tone[2];
    end
    cmax = (tone[0] > tone[1]) ? tone[0] : tone[1];
    if (tone[2] > cmax) begin
      cmax = tone[2];
    end
  end

  // Spread test on the merged range, and the verdict it leads to.
  always_comb begin
    exceed  = (highest_tone > lowest_tone) && ((highest_tone - lowest_tone) > tone_slack);
    rej_now = rejected || (job_do && exceed);
    cnt_now = any_counted || (job_do && !exceed);
    emit_ok = !out_valid || m_tready;
  end

  // Sequencer: take a pixel, divide it if it is counted, merge, then check and report.
  always_comb begin
    state_next = state;
    pop        = 1'b0;
    unique case (state)
      micon_pkg::ST_IDLE: begin
        if (!q_stat.empty) begin
          pop        = 1'b1;
          state_next = (head.take && !rejected) ? micon_pkg::ST_DIV : micon_pkg::ST_MERGE;
        end
      end
      micon_pkg::ST_DIV: begin
        if (step == '0) begin
          state_next = micon_pkg::ST_MERGE;
        end
      end
      micon_pkg::ST_MERGE: begin
        state_next = micon_pkg::ST_CHECK;
      end
      micon_pkg::ST_CHECK: begin
        if (!job_last || emit_ok) begin
          state_next = micon_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = micon_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= micon_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Divider datapath. Below saturation the top byte of chan*255 is already
  // smaller than alpha, so eight restoring steps give the whole quotient.
  always_ff @(posedge clk) begin
    if (state == micon_pkg::ST_IDLE && pop) begin
      job_do    <= head.take && !rejected;
      job_last  <= head.last;
      job_alpha <= head.alpha;
      step      <= STEP_W'(micon_pkg::QUO_BITS - 1);
      for (int i = 0; i < LANES; i++) begin
        logic [15:0] dvd;
        dvd    = {chan_in[i], 8'd0} - {8'd0, chan_in[i]};
        sat[i] <= (chan_in[i] >= head.alpha);
        rem[i] <= dvd[15:8];
        quo[i] <= dvd[7:0];
      end
    end else if (state == micon_pkg::ST_DIV) begin
      step <= step - STEP_W'(1);
      for (int i = 0; i < LANES; i++) begin
        logic [8:0] trial;
        logic       ge;
        trial  = {rem[i], quo[i][7]};
        ge     = (trial >= {1'b0, job_alpha});
        rem[i] <= ge ? 8'(trial - {1'b0, job_alpha}) : trial[7:0];
        quo[i] <= {quo[i][6:0], ge};
      end
    end
  end

  // Image state and the result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      lowest_tone  <= micon_pkg::LOWEST_TONE_RESET;
      highest_tone <= micon_pkg::HIGHEST_TONE_RESET;
      any_counted  <= 1'b0;
      rejected     <= 1'b0;
      out_valid    <= 1'b0;
      out_mask     <= 1'b0;
    end else begin
      if (out_valid && m_tready) begin
        out_valid <= 1'b0;
      end
      if (state == micon_pkg::ST_MERGE && job_do) begin
        if (cmax > highest_tone) begin
          highest_tone <= cmax;
        end
        if (cmin < lowest_tone) begin
          lowest_tone <= cmin;
        end
      end
      if (state == micon_pkg::ST_CHECK) begin
        if (!job_last) begin
          rejected    <= rej_now;
          any_counted <= cnt_now;
        end else if (emit_ok) begin
          out_valid    <= 1'b1;
          out_mask     <= cnt_now && !rej_now;
          lowest_tone  <= micon_pkg::LOWEST_TONE_RESET;
          highest_tone <= micon_pkg::HIGHEST_TONE_RESET;
          any_counted  <= 1'b0;
          rejected     <= 1'b0;
        end
      end
    end
  end

endmodule

`default_nettype wire

// ===== design/monochrome_icon_detector_core.sv =====
`default_nettype none

// Channel   Direction  Word contents (lowest bits first)
// s_*       in         tdata: pixel_word[31:0]; tlast: last_pixel
// m_*       out        tdata: is_mask[0], zero[7:1]; one word after each last pixel
// cfg_*     in         cfg_index: register index; cfg_data: register value
//
// A counted pixel passes through the back end in order: it is taken from the queue,
// then eight divider steps run (one quotient bit per cycle in each of three channel
// lanes), then the tone range is merged and checked. A skipped pixel skips the divider.
// Reset is synchronous; it empties the queue and restores registers and image state.
// The input queue keeps taking words while the back end divides, as long as it has room;
// a result waiting on m_tready stalls only the last pixel's check step.
module monochrome_icon_detector_core #(
  parameter int unsigned QUEUE_DEPTH = micon_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [31:0] s_tdata,    // pixel_word[31:0]
  input  wire logic        s_tlast,    // last_pixel
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [7:0]       m_tdata,    // is_mask[0], zero[7:1]
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [7:0]  cfg_index,
  input  wire logic [7:0]  cfg_data
);

  logic [7:0]             tone_slack;
  logic [7:0]             alpha_floor;
  logic                   q_push;
  logic                   q_pop;
  micon_pkg::entry_t      push_entry;
  micon_pkg::entry_t      head;
  micon_pkg::queue_stat_t q_stat;

  // Configuration registers; unknown indexes are ignored.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      tone_slack  <= micon_pkg::TONE_SLACK_RESET;
      alpha_floor <= micon_pkg::ALPHA_FLOOR_RESET;
    end else if (cfg_valid) begin
      if (cfg_index == micon_pkg::REG_TONE_SLACK) begin
        tone_slack <= cfg_data;
      end else if (cfg_index == micon_pkg::REG_ALPHA_FLOOR) begin
        alpha_floor <= cfg_data;
      end
    end
  end

  micon_front u_front (
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tlast     (s_tlast),
    .alpha_floor (alpha_floor),
    .q_stat      (q_stat),
    .push        (q_push),
    .entry       (push_entry)
  );

  micon_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_entry (push_entry),
    .pop        (q_pop),
    .head       (head),
    .q_stat     (q_stat)
  );

  micon_back u_back (
    .clk        (clk),
    .rst        (rst),
    .tone_slack (tone_slack),
    .head       (head),
    .q_stat     (q_stat),
    .pop        (q_pop),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata)
  );

  // The queue is never full and empty at once.
  a_queue_state: assert property (@(posedge clk) disable iff (rst)
    !(q_stat.full && q_stat.empty))
    else $error("queue reports full and empty together");

  // The back end only takes a pixel that is there.
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !q_stat.empty)
    else $error("pop from an empty queue");

  // The front end never writes into a full queue.
  a_push_room: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_stat.full)
    else $error("push into a full queue");

endmodule

`default_nettype wire
